/* hw/rtl/byte_march_memory_test_defines.svh */
// Assertion macros shared by the march test checker.
`ifndef BYTE_MARCH_MEMORY_TEST_DEFINES_SVH
`define BYTE_MARCH_MEMORY_TEST_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BMT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("march test check failed");

// next-cycle implication, disabled in reset
`define BMT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("march test check failed");

`endif

/* hw/rtl/bmt_pkg.sv */
// Types, constants and helpers for the byte march memory test sequencer.
package bmt_pkg;

  localparam int ADDR_BITS = 32;
  localparam int CMP_W     = (ADDR_BITS > 32) ? ADDR_BITS : 32;

  typedef logic [ADDR_BITS-1:0] addr_t;

  localparam addr_t ADDR_MASK = {ADDR_BITS{1'b1}};

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FILL,
    PH_CF1,
    PH_CF2,
    PH_CF3,
    PH_CHK,
    PH_INCW,
    PH_INCC
  } phase_t;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic REG_START  = 1'b0;
  localparam logic REG_LENGTH = 1'b1;

  localparam logic [31:0] LENGTH_RST = 32'd16;

  localparam logic [7:0] PAT_00 = 8'h00;
  localparam logic [7:0] PAT_55 = 8'h55;
  localparam logic [7:0] PAT_AA = 8'hAA;
  localparam logic [7:0] PAT_FF = 8'hFF;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
  } cfg_t;

  typedef struct packed {
    logic       command;
    logic [7:0] read_byte;
  } item_t;

  // packed so that write_enable lands in bit 0
  typedef struct packed {
    logic [3:0]  pad;
    logic [7:0]  fail_expected_byte;
    logic [7:0]  fail_read_byte;
    logic [31:0] fail_address;
    logic        run_failed;
    logic        run_done;
    logic        next_needs_read;
    logic [31:0] next_address;
    logic [7:0]  write_byte;
    logic [31:0] write_address;
    logic        write_enable;
  } res_t;

  function automatic logic phase_reads(phase_t p);
    return (p == PH_CF1) || (p == PH_CF2) || (p == PH_CF3) ||
           (p == PH_CHK) || (p == PH_INCC);
  endfunction

endpackage

/* hw/rtl/bmt_cfg.sv */
// APB register file holding the region start and length.
module bmt_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready,
  output bmt_pkg::cfg_t cfg
);
  import bmt_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_paddr[2])
        REG_START:  cfg_nxt.start  = cfg_pwdata;
        REG_LENGTH: cfg_nxt.length = cfg_pwdata;
        default:    cfg_nxt        = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_START:  cfg_prdata = cfg_r.start;
      REG_LENGTH: cfg_prdata = cfg_r.length;
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start  <= '0;
      cfg_r.length <= LENGTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* hw/rtl/bmt_in_stage.sv */
// Input register for step items.
module bmt_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,
  input  logic           in_tuser,
  input  logic           take,
  output logic           valid,
  output bmt_pkg::item_t item
);
  import bmt_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  load;

  assign in_tready = !valid_r || take;
  assign load      = in_tvalid && in_tready;
  assign valid_nxt = load || (valid_r && !take);
  assign valid     = valid_r;
  assign item      = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.command   <= in_tuser;
      item_r.read_byte <= in_tdata;
    end
  end

endmodule

/* hw/rtl/bmt_seq.sv */
// March phase sequencer: state registers and single-step next-state logic.
module bmt_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  bmt_pkg::cfg_t  cfg,
  input  bmt_pkg::item_t item,
  input  logic           step,
  output bmt_pkg::res_t  res
);
  import bmt_pkg::*;

  phase_t      phase_r,    phase_nxt;
  addr_t       cursor_r,   cursor_nxt;
  logic        finished_r, finished_nxt;
  logic        mis_r,      mis_nxt;
  addr_t       mis_addr_r, mis_addr_nxt;
  logic [7:0]  mis_rd_r,   mis_rd_nxt;
  logic [7:0]  mis_exp_r,  mis_exp_nxt;

  addr_t       start_a;
  addr_t       off;
  logic [7:0]  incb;
  logic [31:0] lenm1;
  logic [CMP_W-1:0] lenm1_w;
  logic [CMP_W-1:0] lenm1_sat;
  logic        last;
  logic        check;
  logic [7:0]  expect_b;
  logic [7:0]  wpat;
  logic        we;
  addr_t       waddr;
  logic [7:0]  wbyte;

  assign start_a   = addr_t'(cfg.start);
  assign off       = cursor_r - start_a;
  assign incb      = off[7:0];
  assign lenm1     = (cfg.length == 32'd0) ? 32'd0 : cfg.length - 32'd1;
  assign lenm1_w   = CMP_W'(lenm1);
  assign lenm1_sat = (lenm1_w > CMP_W'(ADDR_MASK)) ? CMP_W'(ADDR_MASK) : lenm1_w;
  assign last      = CMP_W'(off) >= lenm1_sat;
  assign check     = phase_reads(phase_r);

  always_comb begin
    expect_b = PAT_00;
    wpat     = PAT_00;
    case (phase_r)
      PH_FILL: wpat = PAT_00;
      PH_CF1: begin
        expect_b = PAT_00;
        wpat     = PAT_55;
      end
      PH_CF2: begin
        expect_b = PAT_55;
        wpat     = PAT_AA;
      end
      PH_CF3: begin
        expect_b = PAT_AA;
        wpat     = PAT_FF;
      end
      PH_CHK:  expect_b = PAT_FF;
      PH_INCW: wpat     = incb;
      PH_INCC: expect_b = incb;
      default: begin
        expect_b = PAT_00;
        wpat     = PAT_00;
      end
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    cursor_nxt   = cursor_r;
    finished_nxt = finished_r;
    mis_nxt      = mis_r;
    mis_addr_nxt = mis_addr_r;
    mis_rd_nxt   = mis_rd_r;
    mis_exp_nxt  = mis_exp_r;
    we           = 1'b0;
    waddr        = '0;
    wbyte        = '0;
    if (item.command == CMD_START) begin
      finished_nxt = 1'b0;
      mis_nxt      = 1'b0;
      mis_addr_nxt = '0;
      mis_rd_nxt   = '0;
      mis_exp_nxt  = '0;
      cursor_nxt   = start_a;
      phase_nxt    = PH_FILL;
    end else if (!finished_r && phase_r != PH_IDLE) begin
      waddr = cursor_r;
      if (check && item.read_byte != expect_b) begin
        mis_nxt      = 1'b1;
        mis_addr_nxt = cursor_r;
        mis_rd_nxt   = item.read_byte;
        mis_exp_nxt  = expect_b;
        finished_nxt = 1'b1;
        phase_nxt    = PH_IDLE;
      end else begin
        if (phase_r != PH_CHK && phase_r != PH_INCC) begin
          we    = 1'b1;
          wbyte = wpat;
        end
        if (last) begin
          cursor_nxt = start_a;
          if (phase_r == PH_INCC) begin
            phase_nxt    = PH_IDLE;
            finished_nxt = 1'b1;
          end else begin
            phase_nxt = phase_t'(phase_r + 3'd1);
          end
        end else begin
          cursor_nxt = cursor_r + addr_t'(1);
        end
      end
    end
  end

  always_comb begin
    res                    = '0;
    res.write_enable       = we;
    res.write_address      = 32'(waddr);
    res.write_byte         = wbyte;
    res.next_address       = 32'(cursor_nxt);
    res.next_needs_read    = !finished_nxt && phase_reads(phase_nxt);
    res.run_done           = finished_nxt;
    res.run_failed         = mis_nxt;
    res.fail_address       = 32'(mis_addr_nxt);
    res.fail_read_byte     = mis_rd_nxt;
    res.fail_expected_byte = mis_exp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      cursor_r   <= '0;
      finished_r <= 1'b0;
      mis_r      <= 1'b0;
      mis_addr_r <= '0;
      mis_rd_r   <= '0;
      mis_exp_r  <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      cursor_r   <= cursor_nxt;
      finished_r <= finished_nxt;
      mis_r      <= mis_nxt;
      mis_addr_r <= mis_addr_nxt;
      mis_rd_r   <= mis_rd_nxt;
      mis_exp_r  <= mis_exp_nxt;
    end
  end

endmodule

/* hw/rtl/bmt_out_stage.sv */
// Result register driving the output stream.
module bmt_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  bmt_pkg::res_t res,
  output logic          free,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [127:0]  out_tdata
);
  import bmt_pkg::*;

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  assign free       = !valid_r || out_tready;
  assign valid_nxt  = load || (valid_r && !out_tready);
  assign out_tvalid = valid_r;
  assign out_tdata  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

/* hw/rtl/byte_march_memory_test.sv */
// Top level of the byte march memory test sequencer.
//
//   channel  ports        role
//   in       in_t*        step items (tuser = command, tdata = read_byte)
//   out      out_t*       one result per step item
//   cfg      cfg_p*       APB registers: 0x0 region_start, 0x4 region_length
//
// Each step item passes through the input register and then the result
// register; one item per cycle is sustained while the output is not stalled,
// as the next-state path of the phase sequencer is combinational.
// Synchronous active-low reset returns the run to idle, length to 16.
// A stalled output holds its result while the input register still takes one item.
module byte_march_memory_test (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] read_byte
  input  logic         in_tuser,   // [0] command
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] write_enable, [32:1] write_address, [40:33] write_byte,
  // [72:41] next_address, [73] next_needs_read, [74] run_done,
  // [75] run_failed, [107:76] fail_address, [115:108] fail_read_byte,
  // [123:116] fail_expected_byte, [127:124] zero
  output logic [127:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import bmt_pkg::*;

  cfg_t  cfg;
  item_t item;
  res_t  res;
  logic  item_valid;
  logic  out_free;
  logic  step;

  assign step = item_valid && out_free;

  bmt_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  bmt_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .take      (step),
    .valid     (item_valid),
    .item      (item)
  );

  bmt_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .item  (item),
    .step  (step),
    .res   (res)
  );

  bmt_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* hw/rtl/bmt_checker.sv */
// Port-level checker for the march test sequencer, bound to the top level.
`include "byte_march_memory_test_defines.svh"

module bmt_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata
);

  `BMT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `BMT_ASSERT_NOW(a_fail_is_done, out_tvalid && out_tdata[75], out_tdata[74])
  `BMT_ASSERT_NOW(a_done_quiet, out_tvalid && out_tdata[74], !out_tdata[73] && !out_tdata[0])
  `BMT_ASSERT_NOW(a_no_fail_clear, out_tvalid && !out_tdata[75], out_tdata[123:76] == 48'd0)

endmodule

bind byte_march_memory_test bmt_checker u_bmt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* tb/sv/tb_byte_march_memory_test.sv */
// Self-checking testbench for the byte march memory test sequencer.
`timescale 1ns / 1ps

import bmt_pkg::*;

class march_scoreboard;
  logic [31:0] region_start;
  logic [31:0] region_length;
  phase_t      phase;
  logic [31:0] cursor;
  logic        finished;
  logic        mm_seen;
  logic [31:0] mm_addr;
  logic [7:0]  mm_read;
  logic [7:0]  mm_want;
  res_t        pending[$];
  int          errors;
  int          checked;
  int          runs_clean;
  int          runs_stopped;

  function new();
    region_start  = '0;
    region_length = LENGTH_RST;
    phase         = PH_IDLE;
    cursor        = '0;
    finished      = 1'b0;
    mm_seen       = 1'b0;
    mm_addr       = '0;
    mm_read       = '0;
    mm_want       = '0;
    errors        = 0;
    checked       = 0;
    runs_clean    = 0;
    runs_stopped  = 0;
  endfunction

  function logic checks_byte(phase_t p);
    return p inside {PH_CF1, PH_CF2, PH_CF3, PH_CHK, PH_INCC};
  endfunction

  function logic reading();
    return !finished && checks_byte(phase);
  endfunction

  function res_t note(logic cmd, logic [7:0] rd);
    res_t        r;
    logic [31:0] off;
    logic [32:0] len;
    logic [7:0]  want;
    logic [7:0]  pat;
    r = '0;
    if (cmd == CMD_START) begin
      finished = 1'b0;
      mm_seen  = 1'b0;
      mm_addr  = '0;
      mm_read  = '0;
      mm_want  = '0;
      cursor   = region_start;
      phase    = PH_FILL;
    end else if (!finished && phase != PH_IDLE) begin
      off  = cursor - region_start;
      len  = (region_length == 32'd0) ? 33'd1 : {1'b0, region_length};
      want = PAT_00;
      pat  = PAT_00;
      case (phase)
        PH_FILL: pat = PAT_00;
        PH_CF1: begin
          want = PAT_00;
          pat  = PAT_55;
        end
        PH_CF2: begin
          want = PAT_55;
          pat  = PAT_AA;
        end
        PH_CF3: begin
          want = PAT_AA;
          pat  = PAT_FF;
        end
        PH_CHK: want = PAT_FF;
        PH_INCW: pat = off[7:0];
        default: want = off[7:0];
      endcase
      r.write_address = cursor;
      if (checks_byte(phase) && rd != want) begin
        mm_seen  = 1'b1;
        mm_addr  = cursor;
        mm_read  = rd;
        mm_want  = want;
        finished = 1'b1;
        phase    = PH_IDLE;
        runs_stopped++;
      end else begin
        if (phase != PH_CHK && phase != PH_INCC) begin
          r.write_enable = 1'b1;
          r.write_byte   = pat;
        end
        if ({1'b0, off} + 33'd1 >= len) begin
          cursor = region_start;
          if (phase == PH_INCC) begin
            phase    = PH_IDLE;
            finished = 1'b1;
            runs_clean++;
          end else begin
            phase = phase_t'(phase + 3'd1);
          end
        end else begin
          cursor = cursor + 32'd1;
        end
      end
    end
    r.next_address       = cursor;
    r.next_needs_read    = reading();
    r.run_done           = finished;
    r.run_failed         = mm_seen;
    r.fail_address       = mm_addr;
    r.fail_read_byte     = mm_read;
    r.fail_expected_byte = mm_want;
    pending.push_back(r);
    return r;
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 40) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report($sformatf("result %0d %s got %h want %h", checked, name, got, want));
  endtask

  task check(res_t got);
    res_t want;
    checked++;
    if (pending.size() == 0) begin
      report($sformatf("result %0d with no transfer outstanding", checked));
      return;
    end
    want = pending.pop_front();
    field("write_enable", 32'(got.write_enable), 32'(want.write_enable));
    field("write_address", got.write_address, want.write_address);
    field("write_byte", 32'(got.write_byte), 32'(want.write_byte));
    field("next_address", got.next_address, want.next_address);
    field("next_needs_read", 32'(got.next_needs_read), 32'(want.next_needs_read));
    field("run_done", 32'(got.run_done), 32'(want.run_done));
    field("run_failed", 32'(got.run_failed), 32'(want.run_failed));
    field("fail_address", got.fail_address, want.fail_address);
    field("fail_read_byte", 32'(got.fail_read_byte), 32'(want.fail_read_byte));
    field("fail_expected_byte", 32'(got.fail_expected_byte),
          32'(want.fail_expected_byte));
    field("pad", 32'(got.pad), 32'(want.pad));
  endtask
endclass

module tb_byte_march_memory_test;
  localparam realtime RUN_LIMIT = 12ns * 600000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;   // [7:0] read_byte
  logic         in_tuser;   // [0] command
  logic         out_tvalid;
  logic         out_tready;
  // [0] write_enable, [32:1] write_address, [40:33] write_byte,
  // [72:41] next_address, [73] next_needs_read, [74] run_done,
  // [75] run_failed, [107:76] fail_address, [115:108] fail_read_byte,
  // [123:116] fail_expected_byte, [127:124] zero
  logic [127:0] out_tdata;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [2:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  march_scoreboard sb = new();
  logic [7:0]      mem [logic [31:0]];
  int              items_sent = 0;
  int              reg_writes = 0;

  byte_march_memory_test dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("tb_byte_march_memory_test NOT OK");
    $finish;
  end

  // idle mode rotates every 70 transfers: none, sender, receiver, both
  function automatic int send_idle_pct();
    case ((items_sent / 70) % 4)
      1: return 71;
      3: return 31;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case ((items_sent / 70) % 4)
      2: return 71;
      3: return 31;
      default: return 0;
    endcase
  endfunction

  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check(res_t'(out_tdata));
      out_tready <= ($urandom_range(99) >= recv_stall_pct());
    end
  end

  task automatic send(input logic cmd, input logic [7:0] rd);
    res_t r;
    while ($urandom_range(99) < send_idle_pct()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= rd;
    do @(posedge clk); while (!in_tready);
    r = sb.note(cmd, rd);
    if (r.write_enable) mem[r.write_address] = r.write_byte;
    items_sent++;
  endtask

  // one step of a well-formed run; bad_per_mil corrupts the byte read back
  task automatic march_step(input int bad_per_mil);
    logic [7:0] rd;
    if (sb.reading()) begin
      rd = mem.exists(sb.cursor) ? mem[sb.cursor] : 8'($urandom);
      if ($urandom_range(999) < bad_per_mil) rd ^= 8'($urandom_range(255, 1));
    end else begin
      rd = 8'($urandom);
    end
    send(CMD_STEP, rd);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write then read back one register
  task automatic cfg_set(input logic sel, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (sel == REG_START) sb.region_start = val;
    else sb.region_length = val;
    reg_writes++;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== val)
      sb.report($sformatf("register %0d read %h want %h", sel, cfg_prdata, val));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_traffic(input int budget);
    int stop;
    int abort_at;
    int n;
    stop = items_sent + budget;
    while (items_sent < stop) begin
      if ($urandom_range(99) < 85) begin
        send(CMD_START, 8'($urandom));
        abort_at = ($urandom_range(9) == 0) ? $urandom_range(20, 1) : -1;
        n = 0;
        while (!sb.finished && items_sent < stop && n != abort_at) begin
          march_step(10);
          n++;
        end
        if (sb.finished && $urandom_range(3) == 0) march_step(0);
      end else begin
        repeat ($urandom_range(5, 1))
          send(($urandom_range(3) == 0) ? CMD_START : CMD_STEP, 8'($urandom));
      end
    end
  endtask

  task automatic run_phase(input logic [31:0] start, input logic [31:0] length,
                           input int budget);
    drain();
    cfg_set(REG_START, start);
    cfg_set(REG_LENGTH, length);
    random_traffic(budget);
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= CMD_STEP;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: step with no run, full one-byte run at the top address,
    // step after done, mismatch in the first check, step after fail, restart
    send(CMD_STEP, 8'hFF);
    drain();
    cfg_set(REG_START, 32'hFFFF_FFFF);
    cfg_set(REG_LENGTH, 32'd0);
    send(CMD_START, 8'h00);
    repeat (7) march_step(0);
    march_step(0);
    send(CMD_START, 8'hFF);
    march_step(0);
    send(CMD_STEP, 8'hFF);
    send(CMD_STEP, 8'h00);
    send(CMD_START, 8'h00);
    march_step(0);
    march_step(0);
    send(CMD_START, 8'h00);
    repeat (3) march_step(0);
    drain();
    cfg_set(REG_START, 32'hFFFF_FFFF);
    cfg_set(REG_LENGTH, 32'd2);
    send(CMD_START, 8'h00);
    repeat (5) march_step(0);

    run_phase(32'h0000_0000, 32'd16, 140);
    run_phase(32'h0000_0000, 32'd1, 60);
    run_phase(32'hFFFF_FFFF, 32'd2, 80);
    run_phase(32'hFFFF_FFF8, 32'd16, 130);
    run_phase($urandom, 32'd3, 80);
    run_phase($urandom, 32'd40, 300);
    run_phase($urandom, 32'd5, 80);
    run_phase($urandom, 32'hFFFF_FFFF, 60);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 30);
    run_phase(32'h0000_0000, 32'd0, 40);

    drain();
    repeat (8) @(posedge clk);
    $display("Covered %0d transfers in and %0d results over %0d register writes;",
             items_sent, sb.checked, reg_writes);
    $display("%0d march runs completed clean, %0d stopped on a mismatch.",
             sb.runs_clean, sb.runs_stopped);
    if (sb.errors == 0) $display("tb_byte_march_memory_test OK");
    else $display("tb_byte_march_memory_test NOT OK");
    $finish;
  end
endmodule
